// ===== rtl/core/sort_unique_set_defines.svh =====
// Assertion macros shared by the sort_unique_set RTL.
`ifndef SORT_UNIQUE_SET_DEFINES_SVH
`define SORT_UNIQUE_SET_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SUS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check an implication property on every clock edge outside reset.
`define SUS_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`else
`define SUS_ASSERT(lbl, prop, msg)
`define SUS_ASSERT_IMP(lbl, cond, prop, msg)
`endif

`endif

// ===== rtl/core/sus_pkg.sv =====
// Types shared by the sort_unique_set chain and its cells.
package sus_pkg;

    localparam int ValueWidth = 32;

    typedef logic signed [ValueWidth-1:0] value_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic   insert;   // place sample into the sorted chain
        logic   shift;    // move every cell one place toward cell 0
        value_t sample;
    } cell_ctrl_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   less;     // sample sorts before this cell's value
    } cell_link_t;

endpackage

// ===== rtl/core/sus_cell.sv =====
// One cell of the insertion chain: holds one value of the sorted set.
module sus_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sus_pkg::cell_ctrl_t ctrl,
    input  sus_pkg::cell_link_t prev,
    input  sus_pkg::cell_link_t next,
    output sus_pkg::cell_link_t link
);
    import sus_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   less;
    logic   take;

    assign less = valid_reg && (ctrl.sample < value_reg);
    // Take a value when the sample lands here or pushes the left neighbor in.
    assign take = ctrl.insert && (less || (!valid_reg && prev.valid));

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next.value;
            valid_next = next.valid;
        end
        else if (take)
        begin
            value_next = prev.less ? prev.value : ctrl.sample;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.less  = less;

endmodule

// ===== rtl/core/sort_unique_set.sv =====
// Sort a set of signed values held in a chain of insertion cells.
// Usage: send signed 32-bit values on the s_axis channel, one per item, and
// mark the last value of a set with s_axis_tlast. Each accepted value is
// registered into its sorted position in the cell chain, so the chain takes
// a new value with every accepted transfer. Up to DEPTH values are kept;
// further values of the set are dropped and every result of that set
// carries m_axis_tuser = 1. After the last item the chain drains out of
// cell 0 in ascending order, one result per cycle while m_axis_tready
// stays high; the first result reaches the output register after the last
// item has been written into the chain and the drain flag is set. With
// dedupe_enable set, repeated values come out once; a repeat takes a drain
// step that gives no result. m_axis_tlast marks the final result.
// s_axis_tready is low while a set drains. A stalled receiver holds the
// output register and freezes the drain, apart from repeats, which still drop.
// Reset empties the chain and clears dedupe_enable.
// Write dedupe_enable through cfg_we/cfg_wdata only while the block idles.
`include "sort_unique_set_defines.svh"

module sort_unique_set #(
    parameter int DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,       // dedupe_enable
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  sus_pkg::value_t     s_axis_tdata,    // [31:0] sample_value
    input  logic                s_axis_tlast,    // is_final
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output sus_pkg::value_t     m_axis_tdata,    // [31:0] sorted_value
    output logic                m_axis_tlast,    // end_of_set
    output logic                m_axis_tuser     // [0] dropped_any
);
    import sus_pkg::*;

    localparam int CountWidth = $clog2(DEPTH + 1);

    cell_ctrl_t             ctrl;
    cell_link_t [DEPTH-1:0] links;
    logic       [DEPTH-1:0] valid_vec;

    logic                  dedupe_reg;
    logic                  draining_reg;
    logic                  draining_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  drop_reg;
    logic                  drop_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    value_t                out_value_reg;
    value_t                out_value_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  out_user_reg;
    logic                  out_user_next;

    logic in_fire;
    logic full;
    logic skip;
    logic out_free;
    logic shift;
    logic emit;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign full    = (count_reg == CountWidth'(DEPTH));

    // Drop a repeated value unless it is the last one of its run.
    assign skip     = dedupe_reg && links[1].valid && (links[1].value == links[0].value);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign shift    = draining_reg && links[0].valid && (skip || out_free);
    assign emit     = shift && !skip;

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = shift;
    assign ctrl.sample = s_axis_tdata;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_link_t prev_link;
            cell_link_t next_link;

            if (gi == 0)
            begin : g_first
                assign prev_link.value = '0;
                assign prev_link.valid = 1'b1;
                assign prev_link.less  = 1'b0;
            end
            else
            begin : g_inner
                assign prev_link = links[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_link.value = '0;
                assign next_link.valid = 1'b0;
                assign next_link.less  = 1'b0;
            end
            else
            begin : g_body
                assign next_link = links[gi+1];
            end

            sus_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .prev  (prev_link),
                .next  (next_link),
                .link  (links[gi])
            );

            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        drop_next      = drop_reg;
        draining_next  = draining_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;

        if (in_fire)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CountWidth'(1);
            end
            if (s_axis_tlast)
            begin
                // Close the set: latch the drop flag and start the drain.
                drop_next     = overflow_reg || full;
                overflow_next = 1'b0;
                count_next    = '0;
                draining_next = 1'b1;
            end
        end

        if (draining_reg && !links[0].valid)
        begin
            draining_next = 1'b0;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = links[0].value;
            out_last_next  = !links[1].valid;
            out_user_next  = drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dedupe_reg    <= 1'b0;
            draining_reg  <= 1'b0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dedupe_reg <= cfg_wdata;
            end
            draining_reg  <= draining_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_user_reg  <= out_user_next;
    end

    assign s_axis_tready = !draining_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    // Occupied cells always form a prefix of the chain.
    `SUS_ASSERT(a_valid_prefix, ((valid_vec + DEPTH'(1)) & valid_vec) == '0,
        "chain has a gap between occupied cells")
    // While loading, the fill count matches the occupied cells.
    `SUS_ASSERT_IMP(a_count_match, !draining_reg,
        count_reg == CountWidth'($countones(valid_vec)),
        "fill count disagrees with occupied cells")
    // The first two cells are in ascending order.
    `SUS_ASSERT_IMP(a_sorted_head, links[1].valid,
        !(links[1].value < links[0].value),
        "chain head out of order")
    // The drop flag holds for the whole drain of a set.
    `SUS_ASSERT_IMP(a_drop_stable, draining_reg && $past(draining_reg),
        $stable(drop_reg),
        "drop flag changed during drain")

endmodule
